@@ sv/rtccal_pkg.sv @@
// ----------------------------------------------------------------------------
// rtccal_pkg
// types, constants and calendar helpers shared by the calendar clock modules
// ----------------------------------------------------------------------------
package rtccal_pkg;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_SET    = 1'b1;

   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

   typedef struct packed {
      logic        kind;
      logic [31:0] tick_count;
      logic [5:0]  set_second;
      logic [5:0]  set_minute;
      logic [4:0]  set_hour;
      logic [4:0]  set_day;
      logic [3:0]  set_month;
      logic [6:0]  set_year;
      logic [6:0]  set_century;
   } req_type;

   typedef struct packed {
      logic        second_advanced;
      logic [5:0]  cur_second;
      logic [5:0]  cur_minute;
      logic [4:0]  cur_hour;
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [6:0]  cur_year;
      logic [6:0]  cur_century;
      logic [2:0]  cur_weekday;
   } rsp_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [6:0] century;
      logic [2:0] weekday;
   } time_type;

   // 2000-01-01 00:00:00, a saturday
   localparam time_type TIME_RESET = '{
      second:  6'd0,
      minute:  6'd0,
      hour:    5'd0,
      day:     5'd1,
      month:   4'd1,
      year:    7'd0,
      century: 7'd21,
      weekday: 3'd6
   };

   // full year + 400 as hundreds * 100 + rest, rest below 100
   typedef struct packed {
      logic [7:0] hundreds;
      logic [6:0] rest;
   } year_split_type;

   function automatic year_split_type split_year(input logic [6:0] century,
                                                 input logic [6:0] year);
      year_split_type ys;
      if (year >= 7'd100) begin
         ys.hundreds = {1'b0, century} + 8'd4;
         ys.rest     = year - 7'd100;
      end else begin
         ys.hundreds = {1'b0, century} + 8'd3;
         ys.rest     = year;
      end
      return ys;
   endfunction

   function automatic logic is_leap(input year_split_type ys);
      return ((ys.rest[1:0] == 2'd0) && (ys.rest != 7'd0)) ||
             ((ys.rest == 7'd0) && (ys.hundreds[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

@@ sv/soft_rtc_calendar.sv @@
// ----------------------------------------------------------------------------
// soft_rtc_calendar
// calendar clock driven by samples of a free-running 32-bit tick counter
// ----------------------------------------------------------------------------
// request channel (req_valid, req_stall, req_data): each transaction is either
// a tick counter sample or a set of the date and time. a sample advances the
// clock one second when at least ticks_per_second ticks have passed since the
// last counted second; the carry runs through minute, hour, day, month, year
// and century. a set loads all fields and derives the weekday.
// response channel (rsp_valid, rsp_stall, rsp_data): one transaction per
// request with the time after it and a flag for an advanced second.
// csr port: csr_write_enable with csr_write_data writes ticks_per_second;
// write only while no request is in flight.
// requests pass one input register and one response register with the
// calendar update between them. one request per cycle is sustained while the
// response is not stalled; the rate is set by the single calendar update stage.
// a stalled response holds; a full input register holds too and sets req_stall.
// reset brings the clock to 2000-01-01 00:00:00 saturday, last tick 0 and
// ticks_per_second 1000, and empties both registers.
// ----------------------------------------------------------------------------
module soft_rtc_calendar
   import rtccal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic        in_valid_ff;
   logic        in_valid_in;
   req_type     in_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     result;
   logic [15:0] tps_ff;
   logic        move;
   logic        accept;

   assign move         = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~move;
   assign accept       = req_valid & ~req_stall;
   assign in_valid_in  = accept | (in_valid_ff & ~move);
   assign rsp_valid_in = move | (rsp_valid_ff & rsp_stall);

   rtccal_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (move),
      .item             (in_data_ff),
      .ticks_per_second (tps_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tps_ff       <= TICKS_PER_SECOND_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            tps_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/rtccal_weekday.sv @@
// ----------------------------------------------------------------------------
// rtccal_weekday
// weekday of a date by the kim larsson formula, 1 monday through 7 sunday
// ----------------------------------------------------------------------------
module rtccal_weekday
   import rtccal_pkg::*;
(
   input  logic [4:0] day,
   input  logic [3:0] month,
   input  logic [6:0] year,
   input  logic [6:0] century,
   output logic [2:0] weekday
);

   // floor(3 * (m + 1) / 5)
   function automatic logic [3:0] month_term(input logic [3:0] m);
      logic [3:0] t;
      case (m)
         4'd0:    t = 4'd0;
         4'd1:    t = 4'd1;
         4'd2:    t = 4'd1;
         4'd3:    t = 4'd2;
         4'd4:    t = 4'd3;
         4'd5:    t = 4'd3;
         4'd6:    t = 4'd4;
         4'd7:    t = 4'd4;
         4'd8:    t = 4'd5;
         4'd9:    t = 4'd6;
         4'd10:   t = 4'd6;
         4'd11:   t = 4'd7;
         4'd12:   t = 4'd7;
         4'd13:   t = 4'd8;
         default: t = 4'd9;
      endcase
      return t;
   endfunction

   // octal digit folding, 8 is 1 mod 7
   function automatic logic [2:0] mod7(input logic [9:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = {2'b0, x[2:0]} + {2'b0, x[5:3]} + {2'b0, x[8:6]} + {4'b0, x[9]};
      s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
      s3 = s2[2:0] + {2'b0, s2[3]};
      return (s3 == 3'd7) ? 3'd0 : s3;
   endfunction

   year_split_type ys;
   logic [7:0]     q;
   logic [6:0]     r;
   logic [3:0]     m;
   logic [9:0]     sum;
   logic [2:0]     w;

   always_comb begin
      ys = split_year(century, year);
      q  = ys.hundreds;
      r  = ys.rest;
      m  = month;
      if ((month == 4'd1) || (month == 4'd2)) begin
         m = month + 4'd12;
         if (r == 7'd0) begin
            q = q - 8'd1;
            r = 7'd99;
         end else begin
            r = r - 7'd1;
         end
      end
      // 100q - q + 25q is 5q mod 7, y/400 is q/4
      sum = {5'b0, day} + 10'd1 + {5'b0, m, 1'b0} + {6'b0, month_term(m)}
          + {q, 2'b0} + {2'b0, q} + {4'b0, q[7:2]}
          + {3'b0, r} + {5'b0, r[6:2]};
      w   = mod7(sum);
   end

   assign weekday = (w == 3'd0) ? 3'd7 : w;

endmodule

@@ sv/rtccal_core.sv @@
// ----------------------------------------------------------------------------
// rtccal_core
// calendar state, second detection on tick samples and carry cascade
// ----------------------------------------------------------------------------
module rtccal_core
   import rtccal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   input  logic [15:0] ticks_per_second,
   output rsp_type     result
);

   time_type       time_ff;
   time_type       time_in;
   logic [31:0]    last_tick_ff;
   logic [31:0]    last_tick_in;
   logic [31:0]    diff;
   logic           advanced;
   logic [2:0]     set_weekday;
   logic [4:0]     dim;
   logic [6:0]     sec_inc;
   logic [6:0]     min_inc;
   logic [5:0]     hour_inc;
   logic [5:0]     day_inc;
   logic [4:0]     month_inc;
   logic [7:0]     year_inc;

   rtccal_weekday u_weekday (
      .day     (item.set_day),
      .month   (item.set_month),
      .year    (item.set_year),
      .century (item.set_century),
      .weekday (set_weekday)
   );

   assign dim = month_days(time_ff.month, is_leap(split_year(time_ff.century, time_ff.year)));

   always_comb begin
      time_in      = time_ff;
      last_tick_in = last_tick_ff;
      advanced     = 1'b0;
      diff         = item.tick_count - last_tick_ff;
      sec_inc      = {1'b0, time_ff.second} + 7'd1;
      min_inc      = {1'b0, time_ff.minute} + 7'd1;
      hour_inc     = {1'b0, time_ff.hour} + 6'd1;
      day_inc      = {1'b0, time_ff.day} + 6'd1;
      month_inc    = {1'b0, time_ff.month} + 5'd1;
      year_inc     = {1'b0, time_ff.year} + 8'd1;
      if (item.kind == KIND_SET) begin
         time_in.second  = item.set_second;
         time_in.minute  = item.set_minute;
         time_in.hour    = item.set_hour;
         time_in.day     = item.set_day;
         time_in.month   = item.set_month;
         time_in.year    = item.set_year;
         time_in.century = item.set_century;
         time_in.weekday = set_weekday;
      end else if (diff >= {16'b0, ticks_per_second}) begin
         advanced     = 1'b1;
         last_tick_in = item.tick_count;
         if (sec_inc < 7'd60) begin
            time_in.second = sec_inc[5:0];
         end else begin
            time_in.second = 6'd0;
            if (min_inc < 7'd60) begin
               time_in.minute = min_inc[5:0];
            end else begin
               time_in.minute = 6'd0;
               if (hour_inc < 6'd24) begin
                  time_in.hour = hour_inc[4:0];
               end else begin
                  time_in.hour    = 5'd0;
                  time_in.weekday = (time_ff.weekday >= 3'd7) ? 3'd1
                                                              : time_ff.weekday + 3'd1;
                  if (day_inc <= {1'b0, dim}) begin
                     time_in.day = day_inc[4:0];
                  end else begin
                     time_in.day = 5'd1;
                     if (month_inc <= 5'd12) begin
                        time_in.month = month_inc[3:0];
                     end else begin
                        time_in.month = 4'd1;
                        if (year_inc <= 8'd99) begin
                           time_in.year = year_inc[6:0];
                        end else begin
                           time_in.year    = 7'd0;
                           time_in.century = (time_ff.century >= 7'd100) ? 7'd1
                                                                         : time_ff.century + 7'd1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= TIME_RESET;
         last_tick_ff <= 32'd0;
      end else if (step) begin
         time_ff      <= time_in;
         last_tick_ff <= last_tick_in;
      end
   end

   always_comb begin
      result.second_advanced = advanced;
      result.cur_second      = time_in.second;
      result.cur_minute      = time_in.minute;
      result.cur_hour        = time_in.hour;
      result.cur_day         = time_in.day;
      result.cur_month       = time_in.month;
      result.cur_year        = time_in.year;
      result.cur_century     = time_in.century;
      result.cur_weekday     = time_in.weekday;
   end

endmodule

@@ sv/rtccal_checker.sv @@
// ----------------------------------------------------------------------------
// rtccal_checker
// port-level checks of the calendar clock, bound to the top level
// ----------------------------------------------------------------------------
module rtccal_checker
   import rtccal_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_weekday_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cur_weekday != 3'd0)
      else $error("weekday zero");

   a_advance_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.second_advanced |-> rsp_data.cur_second < 6'd60)
      else $error("advanced second out of range");

endmodule

bind soft_rtc_calendar rtccal_checker u_checker (.*);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for the soft_rtc_calendar tick-driven calendar clock
// ----------------------------------------------------------------------------
// drives counter samples and date/time loads through the request channel and
// checks each response against a calendar predictor kept in the testbench.
// directed tests cover reset values, counter wrap, month/year/century carries,
// leap years and out-of-range loads; random traffic runs at several second
// rates, mostly with random gaps and stalls on both channels; one test holds
// the response side off long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rtccal_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   // calendar predictor state
   logic [31:0] rate_ticks;
   logic [31:0] last_tick;
   int          cal_sec, cal_min, cal_hour, cal_day, cal_mon, cal_year, cal_cent, cal_wday;

   rsp_type     expected_times[$];
   int          mismatch_count = 0;
   bit          steady = 1'b0;
   int          hold_left = 0;

   soft_rtc_calendar u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic bit leap_year(input int c, input int y);
      int full;
      full = c * 100 + y + 300;
      return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
   endfunction

   function automatic int days_in(input int mo, input int c, input int y);
      int n;
      case (mo)
         2:             n = leap_year(c, y) ? 29 : 28;
         4, 6, 9, 11:   n = 30;
         default:       n = 31;
      endcase
      return n;
   endfunction

   function automatic int weekday_of(input int d, input int mo, input int y, input int c);
      int full;
      int m;
      int w;
      full = c * 100 + y + 300;
      m = mo;
      if (m == 1 || m == 2) begin
         m = m + 12;
         full = full - 1;
      end
      w = (d + 1 + 2 * m + (3 * (m + 1)) / 5 + full + full / 4 - full / 100 + full / 400) % 7;
      return (w == 0) ? 7 : w;
   endfunction

   function automatic void calendar_reset();
      rate_ticks = {16'd0, TICKS_PER_SECOND_RESET};
      last_tick  = '0;
      cal_sec    = 0;
      cal_min    = 0;
      cal_hour   = 0;
      cal_day    = 1;
      cal_mon    = 1;
      cal_year   = 0;
      cal_cent   = 21;
      cal_wday   = 6;
   endfunction

   function automatic void advance_one_second();
      cal_sec = cal_sec + 1;
      if (cal_sec < 60) return;
      cal_sec = 0;
      cal_min = cal_min + 1;
      if (cal_min < 60) return;
      cal_min = 0;
      cal_hour = cal_hour + 1;
      if (cal_hour < 24) return;
      cal_hour = 0;
      cal_wday = (cal_wday >= 7) ? 1 : cal_wday + 1;
      cal_day = cal_day + 1;
      if (cal_day <= days_in(cal_mon, cal_cent, cal_year)) return;
      cal_day = 1;
      cal_mon = cal_mon + 1;
      if (cal_mon <= 12) return;
      cal_mon = 1;
      cal_year = cal_year + 1;
      if (cal_year <= 99) return;
      cal_year = 0;
      cal_cent = (cal_cent >= 100) ? 1 : cal_cent + 1;
   endfunction

   function automatic rsp_type calendar_step(input req_type r);
      rsp_type     o;
      logic [31:0] diff;
      o.second_advanced = 1'b0;
      if (r.kind == KIND_SAMPLE) begin
         diff = r.tick_count - last_tick;
         if (diff >= rate_ticks) begin
            last_tick = r.tick_count;
            advance_one_second();
            o.second_advanced = 1'b1;
         end
      end else begin
         cal_sec  = r.set_second;
         cal_min  = r.set_minute;
         cal_hour = r.set_hour;
         cal_day  = r.set_day;
         cal_mon  = r.set_month;
         cal_year = r.set_year;
         cal_cent = r.set_century;
         cal_wday = weekday_of(cal_day, cal_mon, cal_year, cal_cent);
      end
      o.cur_second  = cal_sec[5:0];
      o.cur_minute  = cal_min[5:0];
      o.cur_hour    = cal_hour[4:0];
      o.cur_day     = cal_day[4:0];
      o.cur_month   = cal_mon[3:0];
      o.cur_year    = cal_year[6:0];
      o.cur_century = cal_cent[6:0];
      o.cur_weekday = cal_wday[2:0];
      return o;
   endfunction

   function automatic req_type random_fields();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type sample_at(input logic [31:0] t);
      req_type r;
      r = random_fields();
      r.kind = KIND_SAMPLE;
      r.tick_count = t;
      return r;
   endfunction

   function automatic req_type set_to(input int s, input int mi, input int h, input int d,
                                      input int mo, input int y, input int c);
      req_type r;
      r = random_fields();
      r.kind        = KIND_SET;
      r.set_second  = s[5:0];
      r.set_minute  = mi[5:0];
      r.set_hour    = h[4:0];
      r.set_day     = d[4:0];
      r.set_month   = mo[3:0];
      r.set_year    = y[6:0];
      r.set_century = c[6:0];
      return r;
   endfunction

   function automatic req_type random_req();
      int pick;
      int mo, c, y, d;
      pick = $urandom_range(99);
      mo = $urandom_range(12, 1);
      c  = ($urandom_range(3) == 0) ? $urandom_range(100, 1) : $urandom_range(22, 19);
      y  = $urandom_range(99);
      d  = days_in(mo, c, y);
      if (pick < 55)
         return sample_at(last_tick + rate_ticks + $urandom_range(2));
      if (pick < 70)
         return sample_at(last_tick + ((rate_ticks == 0) ? 0 : $urandom_range(rate_ticks - 1)));
      if (pick < 80) begin
         if ($urandom_range(3) == 0) begin
            mo = 12;
            d  = 31;
            y  = 99;
         end
         return set_to($urandom_range(59, 55), 59, 23, d, mo, y, c);
      end
      if (pick < 88)
         return set_to($urandom_range(59), $urandom_range(59), $urandom_range(23),
                       $urandom_range(d, 1), mo, y, c);
      if (pick < 94)
         return set_to($urandom_range(63), $urandom_range(63), $urandom_range(31),
                       $urandom_range(31), $urandom_range(15), $urandom_range(127),
                       $urandom_range(127));
      return sample_at($urandom());
   endfunction

   // one request transaction, prediction taken at the accepting edge
   task automatic send_req(input req_type r);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_times.push_back(calendar_step(r));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rate(input logic [15:0] v);
      wait_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      rate_ticks = {16'd0, v};
   endtask

   task automatic set_then_tick(input req_type s);
      send_req(s);
      send_req(sample_at(last_tick + rate_ticks));
   endtask

   task automatic test_reset_values();
      send_req(sample_at(32'd0));
      send_req(sample_at(32'd999));
      send_req(sample_at(32'd1000));
   endtask

   task automatic test_counter_wrap();
      send_req(sample_at(32'hFFFF_FFFF));
      send_req(sample_at(32'd998));
      send_req(sample_at(32'd999));
   endtask

   task automatic test_calendar_carries();
      set_then_tick(set_to(59, 59, 23, 28, 2, 0, 21));
      set_then_tick(set_to(59, 59, 23, 28, 2, 0, 20));
      set_then_tick(set_to(59, 59, 23, 29, 2, 24, 21));
      set_then_tick(set_to(59, 59, 23, 30, 4, 24, 21));
      set_then_tick(set_to(59, 59, 23, 31, 12, 99, 21));
      set_then_tick(set_to(59, 59, 23, 31, 12, 99, 100));
      set_then_tick(set_to(63, 63, 31, 31, 15, 127, 127));
      set_then_tick(set_to(0, 0, 0, 0, 0, 0, 0));
      set_then_tick(set_to(0, 0, 0, 1, 1, 0, 1));
      wait_idle();
   endtask

   task automatic test_random_traffic(input logic [15:0] rate, input int count,
                                      input bit no_gaps);
      write_rate(rate);
      steady = no_gaps;
      repeat (count) send_req(random_req());
      wait_idle();
      steady = 1'b0;
   endtask

   task automatic test_rate_extremes();
      test_random_traffic(16'd0, 150, 1'b0);
      test_random_traffic(16'hFFFF, 150, 1'b0);
      test_random_traffic(16'd1, 200, 1'b0);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_left = 300;
      steady = 1'b1;
      repeat (40) send_req(random_req());
      wait_idle();
      steady = 1'b0;
   endtask

   // response side: random stalls, or a long hold when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = !steady && ($urandom_range(99) < 23);
      end
   end

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_times.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            compare_field("second_advanced", expected_times[0].second_advanced,
                          rsp_data.second_advanced);
            compare_field("cur_second", expected_times[0].cur_second, rsp_data.cur_second);
            compare_field("cur_minute", expected_times[0].cur_minute, rsp_data.cur_minute);
            compare_field("cur_hour", expected_times[0].cur_hour, rsp_data.cur_hour);
            compare_field("cur_day", expected_times[0].cur_day, rsp_data.cur_day);
            compare_field("cur_month", expected_times[0].cur_month, rsp_data.cur_month);
            compare_field("cur_year", expected_times[0].cur_year, rsp_data.cur_year);
            compare_field("cur_century", expected_times[0].cur_century, rsp_data.cur_century);
            compare_field("cur_weekday", expected_times[0].cur_weekday, rsp_data.cur_weekday);
            void'(expected_times.pop_front());
         end
      end
   end

   initial begin
      calendar_reset();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_counter_wrap();
      test_calendar_carries();
      test_rate_extremes();
      test_backpressure();
      test_random_traffic(16'd7, 300, 1'b1);
      test_random_traffic(16'd1000, 400, 1'b0);
      test_random_traffic(16'($urandom_range(65535, 1)), 250, 1'b0);
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
